// ===== design/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// Edge-timed frame receiver package
// Transfer types, operation codes and timing constants shared by the
// receiver core and its decode datapath.
// ----------------------------------------------------------------------------
package efr_pkg;

    // Operation codes carried by each input transfer.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Bit timing in microseconds and frame slot geometry.
    localparam int BIT_TIME_US   = 16;
    localparam int BIT_TIME_LOG2 = 4;
    localparam int HALF_BIT_US   = 8;
    localparam int SLOT_BITS     = 10;
    localparam int SEG_MAX       = 255;
    localparam int SEG_W         = 8;

    // Deltas at or above this value round to more than SEG_MAX bits.
    localparam int SEG_SAT_DELTA = (SEG_MAX + 1) * BIT_TIME_US - HALF_BIT_US;
    localparam int DELTA_LOW_W   = 12;
    localparam int POS_W         = 9;
    localparam int BCNT_W        = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] edge_time;
        logic        pin_after_edge;
    } efr_in_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic [3:0] byte_index;
        logic       frame_done;
        logic       checksum_ok;
        logic       overflow;
    } efr_out_t;

    // Capture state that does not depend on the frame length parameter.
    typedef struct packed {
        logic [31:0]           last_edge_time;
        logic [SLOT_BITS-1:0]  bit_shift;
        logic [BCNT_W-1:0]     bit_count;
        logic [7:0]            xor_acc;
        logic                  skip_next;
        logic                  overflow_flag;
    } efr_state_t;

endpackage

// ===== design/efr_step.sv =====
// ----------------------------------------------------------------------------
// Edge-timed frame receiver step logic
// Decodes one registered event against the current capture state and gives
// the next state and an optional result.
// ----------------------------------------------------------------------------
module efr_step #(
    parameter int MAX_FRAME_BYTES = 16,
    parameter int CNT_W           = 5
) (
    input  efr_pkg::efr_in_t    event_in,
    input  efr_pkg::efr_state_t state_cur,
    input  logic [CNT_W-1:0]    byte_count_cur,
    output efr_pkg::efr_state_t state_nxt,
    output logic [CNT_W-1:0]    byte_count_nxt,
    output logic                result_valid,
    output efr_pkg::efr_out_t   result
);

    logic [31:0]                        delta;
    logic [efr_pkg::DELTA_LOW_W-1:0]    rounded;
    logic [efr_pkg::SEG_W-1:0]          seg_len;
    logic [efr_pkg::POS_W-1:0]          end_pos;
    logic [efr_pkg::SLOT_BITS-1:0]      fill_mask;
    logic [efr_pkg::SLOT_BITS-1:0]      new_shift;
    logic                               byte_done;
    logic                               frame_full;
    logic [7:0]                         data;

    // Segment length in bit times, rounded to nearest and saturated.
    assign delta   = event_in.edge_time - state_cur.last_edge_time;
    assign rounded = delta[efr_pkg::DELTA_LOW_W-1:0]
                     + efr_pkg::DELTA_LOW_W'(efr_pkg::HALF_BIT_US);
    assign seg_len = (delta >= 32'(efr_pkg::SEG_SAT_DELTA))
                     ? efr_pkg::SEG_W'(efr_pkg::SEG_MAX)
                     : rounded[efr_pkg::DELTA_LOW_W-1:efr_pkg::BIT_TIME_LOG2];

    assign end_pos = efr_pkg::POS_W'(state_cur.bit_count) + efr_pkg::POS_W'(seg_len);

    // Slot positions covered by this segment; positions past the slot are dropped.
    always_comb begin
        for (int j = 0; j < efr_pkg::SLOT_BITS; j++) begin
            fill_mask[j] = (efr_pkg::POS_W'(j) >= efr_pkg::POS_W'(state_cur.bit_count))
                           && (efr_pkg::POS_W'(j) < end_pos);
        end
    end

    assign new_shift  = state_cur.bit_shift
                        | (event_in.pin_after_edge ? '0 : fill_mask);
    assign byte_done  = end_pos >= efr_pkg::POS_W'(efr_pkg::SLOT_BITS);
    assign frame_full = byte_count_cur >= CNT_W'(MAX_FRAME_BYTES);
    assign data       = new_shift[8:1];

    always_comb begin
        state_nxt      = state_cur;
        byte_count_nxt = byte_count_cur;
        result_valid   = 1'b0;
        result         = '0;

        case (event_in.op)
            efr_pkg::OP_START: begin
                state_nxt                = '0;
                state_nxt.last_edge_time = event_in.edge_time;
                byte_count_nxt           = '0;
            end
            efr_pkg::OP_END: begin
                result_valid       = 1'b1;
                result.frame_done  = 1'b1;
                result.checksum_ok = (state_cur.xor_acc == 8'd0);
                result.overflow    = state_cur.overflow_flag;
            end
            efr_pkg::OP_EDGE: begin
                state_nxt.last_edge_time = event_in.edge_time;
                if (state_cur.skip_next) begin
                    state_nxt.skip_next = 1'b0;
                end else if (byte_done) begin
                    state_nxt.bit_shift = '0;
                    state_nxt.bit_count = '0;
                    state_nxt.skip_next = 1'b1;
                    if (frame_full) begin
                        state_nxt.overflow_flag = 1'b1;
                    end else begin
                        state_nxt.xor_acc = state_cur.xor_acc ^ data;
                        byte_count_nxt    = byte_count_cur + CNT_W'(1);
                        result_valid      = 1'b1;
                        result.byte_valid = 1'b1;
                        result.data_byte  = data;
                        result.byte_index = 4'(byte_count_cur);
                        result.overflow   = state_cur.overflow_flag;
                    end
                end else begin
                    state_nxt.bit_shift = new_shift;
                    state_nxt.bit_count = end_pos[efr_pkg::BCNT_W-1:0];
                end
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase
    end

endmodule

// ===== design/edge_timed_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// Edge-timed frame receiver core
// Rebuilds the bytes of a 16 us per bit serial frame from line edge
// timestamps, keeps an XOR checksum and reports it at the end of capture.
// ----------------------------------------------------------------------------
// Pipeline: an event is held in the input register until the result stage is
// free, is then decoded, and its result is registered in the result stage.
// Throughput: one event per cycle while no result stalls, set by the single
// decode pass between the input register and the result register.
// Reset: aresetn, synchronous and active low, clears the valid flags of both
// stages and all capture state, including the last edge timestamp, to zero.
// ----------------------------------------------------------------------------
module edge_timed_frame_receiver_core #(
    parameter int MAX_FRAME_BYTES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  efr_pkg::efr_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output efr_pkg::efr_out_t m_payload
);

    // The byte counter must hold MAX_FRAME_BYTES itself, since it saturates there.
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    // Input stage: one event waiting for the decode pass.
    logic                in_valid_reg;
    logic                in_valid_next;
    efr_pkg::efr_in_t    in_data_reg;
    efr_pkg::efr_in_t    in_data_next;

    // Result stage: one finished result waiting for its transfer.
    logic                out_valid_reg;
    logic                out_valid_next;
    efr_pkg::efr_out_t   out_data_reg;
    efr_pkg::efr_out_t   out_data_next;

    // Capture state.
    efr_pkg::efr_state_t state_reg;
    efr_pkg::efr_state_t state_next;
    logic [CNT_W-1:0]    byte_count_reg;
    logic [CNT_W-1:0]    byte_count_next;

    efr_pkg::efr_state_t step_state;
    logic [CNT_W-1:0]    step_byte_count;
    logic                step_result_valid;
    efr_pkg::efr_out_t   step_result;
    logic                advance;

    efr_step #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CNT_W           (CNT_W)
    ) u_step (
        .event_in       (in_data_reg),
        .state_cur      (state_reg),
        .byte_count_cur (byte_count_reg),
        .state_nxt      (step_state),
        .byte_count_nxt (step_byte_count),
        .result_valid   (step_result_valid),
        .result         (step_result)
    );

    // The held event is decoded once the result stage is free, or is being
    // emptied by a transfer in this same cycle. Events that give no result
    // still wait for this, which keeps the result order simple.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // A new event is taken whenever the input stage is empty or moves on.
    // While a result stalls, the input register still takes one more event,
    // after which s_ready stays low until the result is transferred.
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_data_next    = in_data_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        state_next      = state_reg;
        byte_count_next = byte_count_reg;

        if (advance) begin
            in_valid_next   = 1'b0;
            state_next      = step_state;
            byte_count_next = step_byte_count;
            out_valid_next  = step_result_valid;
            out_data_next   = step_result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
            byte_count_reg <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edge-timed frame receiver core testbench
// Sends line edge events built from real serial byte frames, mixed with
// random noise events, and checks every result transfer against an
// in-bench prediction of the decoded bytes, checksum and overflow flag.
// ----------------------------------------------------------------------------
module testbench;

    // The one op code that the package leaves unnamed; the core ignores it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int FRAME_BYTES = 16;
    localparam int EVENT_TARGET = 1700;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    efr_pkg::efr_in_t  s_payload = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    efr_pkg::efr_out_t m_payload;

    efr_pkg::efr_in_t  pending_events[$];
    efr_pkg::efr_out_t expected_results[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    logic [31:0] line_time = '0;

    // Receiver state as the decoder should hold it.
    logic [31:0] rx_last_time = '0;
    logic [9:0]  rx_shift = '0;
    int          rx_bit_count = 0;
    logic [7:0]  rx_xor = '0;
    int          rx_byte_count = 0;
    logic        rx_skip = 1'b0;
    logic        rx_overflow = 1'b0;

    edge_timed_frame_receiver_core #(
        .MAX_FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Idle at random, roughly 15 times in a hundred, except for a quiet window in which
    // both sides run flat out.
    function automatic logic idle_now();
        if (cycle_count >= 1500 && cycle_count < 2500) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 15;
    endfunction

    function automatic string describe(efr_pkg::efr_out_t r);
        return {$sformatf("byte_valid=%0d data_byte=%02h byte_index=%0d ",
                          r.byte_valid, r.data_byte, r.byte_index),
                $sformatf("frame_done=%0d checksum_ok=%0d overflow=%0d",
                          r.frame_done, r.checksum_ok, r.overflow)};
    endfunction

    // Works out what one accepted event should produce, updating the
    // predicted receiver state as it goes.
    task automatic decode_event(input efr_pkg::efr_in_t ev);
        logic [31:0]       gap;
        logic [32:0]       rounded;
        int                nbits;
        int                last_pos;
        logic [7:0]        data;
        efr_pkg::efr_out_t res;
        res = '0;
        case (ev.op)
            efr_pkg::OP_START: begin
                rx_shift = '0;
                rx_bit_count = 0;
                rx_xor = '0;
                rx_byte_count = 0;
                rx_skip = 1'b0;
                rx_overflow = 1'b0;
                rx_last_time = ev.edge_time;
            end
            efr_pkg::OP_END: begin
                res.frame_done = 1'b1;
                res.checksum_ok = (rx_xor == 8'h00);
                res.overflow = rx_overflow;
                expected_results.push_back(res);
            end
            efr_pkg::OP_EDGE: begin
                // The segment length wraps with the timestamp and rounds to
                // the nearest whole bit time, saturating at SEG_MAX bits.
                gap = ev.edge_time - rx_last_time;
                rounded = ({1'b0, gap} + 33'(efr_pkg::HALF_BIT_US))
                          / 33'(efr_pkg::BIT_TIME_US);
                nbits = (rounded > 33'(efr_pkg::SEG_MAX)) ? efr_pkg::SEG_MAX
                                                          : int'(rounded);
                rx_last_time = ev.edge_time;
                if (rx_skip) begin
                    rx_skip = 1'b0;
                end else begin
                    last_pos = rx_bit_count + nbits;
                    for (int p = rx_bit_count; p < last_pos && p < efr_pkg::SLOT_BITS;
                         p++) begin
                        if (!ev.pin_after_edge) begin
                            rx_shift[p] = 1'b1;
                        end
                    end
                    rx_bit_count = rx_bit_count + nbits;
                    if (rx_bit_count >= efr_pkg::SLOT_BITS) begin
                        data = rx_shift[8:1];
                        rx_shift = '0;
                        rx_bit_count = 0;
                        rx_skip = 1'b1;
                        if (rx_byte_count >= FRAME_BYTES) begin
                            rx_overflow = 1'b1;
                        end else begin
                            rx_xor = rx_xor ^ data;
                            res.byte_valid = 1'b1;
                            res.data_byte = data;
                            res.byte_index = rx_byte_count[3:0];
                            res.overflow = rx_overflow;
                            rx_byte_count = rx_byte_count + 1;
                            expected_results.push_back(res);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_event(input logic [1:0] op, input logic [31:0] stamp,
                              input logic pin);
        efr_pkg::efr_in_t ev;
        ev.op = op;
        ev.edge_time = stamp;
        ev.pin_after_edge = pin;
        pending_events.push_back(ev);
    endtask

    task automatic push_edge_after(input logic [31:0] delta, input logic pin);
        line_time = line_time + delta;
        push_event(efr_pkg::OP_EDGE, line_time, pin);
    endtask

    // Duration of a segment of the given number of bits, with up to seven
    // microseconds of jitter either way, which still rounds to the same count.
    function automatic logic [31:0] seg_delta(input int nbits);
        return 32'(nbits * efr_pkg::BIT_TIME_US + int'($urandom_range(0, 14)) - 7);
    endfunction

    // Sends the ten bit slot of one byte as runs of equal bits.  The final
    // run may be stretched by extra bits, which the receiver should drop.
    task automatic add_byte(input logic [7:0] data, input logic first_bit,
                            input logic last_bit, input int extra);
        logic [9:0] slot;
        int         i;
        int         run;
        slot = {last_bit, data, first_bit};
        i = 0;
        while (i < efr_pkg::SLOT_BITS) begin
            run = 1;
            while (i + run < efr_pkg::SLOT_BITS && slot[i + run] == slot[i]) begin
                run++;
            end
            push_edge_after(seg_delta((i + run == efr_pkg::SLOT_BITS) ? run + extra : run),
                            !slot[i]);
            i = i + run;
        end
    endtask

    task automatic add_frame();
        int         nbytes;
        logic [7:0] running_xor;
        logic [7:0] data;
        line_time = line_time + (($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(20, 500));
        push_event(efr_pkg::OP_START, line_time, 1'($urandom));
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 6);
        running_xor = '0;
        for (int k = 0; k < nbytes; k++) begin
            data = 8'($urandom);
            // Half the frames close with a byte that zeroes the checksum.
            if (k == nbytes - 1 && $urandom_range(0, 1) == 1) begin
                data = running_xor;
            end
            running_xor = running_xor ^ data;
            // Now and then a stray edge breaks the frame.
            if ($urandom_range(0, 19) == 0) begin
                push_edge_after($urandom_range(0, 400), 1'($urandom));
            end
            add_byte(data, 1'($urandom), 1'($urandom),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0);
            push_edge_after(seg_delta($urandom_range(1, 3)), 1'($urandom));
        end
        if ($urandom_range(0, 9) != 0) begin
            push_event(efr_pkg::OP_END, line_time + $urandom_range(0, 100), 1'($urandom));
        end
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(3, 12);
        repeat (n) begin
            line_time = line_time + (($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(0, 300));
            push_event(2'($urandom), line_time, 1'($urandom));
        end
    endtask

    // Driver: offers the next pending event once the previous transfer has
    // gone, and hands each accepted event to the decoder prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_event(s_payload);
            end
            if (!s_valid || s_ready) begin
                if (pending_events.size() != 0 && !idle_now()) begin
                    s_valid <= 1'b1;
                    s_payload <= pending_events.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %s",
                             $time, describe(m_payload));
                    mismatch_count++;
                end else if (m_payload !== expected_results[0]) begin
                    $display("%0t: mismatch, expected %s, got %s", $time,
                             describe(expected_results[0]), describe(m_payload));
                    mismatch_count++;
                    void'(expected_results.pop_front());
                end else begin
                    void'(expected_results.pop_front());
                end
            end
            m_ready <= !idle_now();
        end
    end

    initial begin
        // Directed part.  An edge and an end of capture arrive before any
        // start, so they work from the reset state; an unused op follows.
        push_edge_after(32'd40, 1'b0);
        push_event(efr_pkg::OP_END, line_time, 1'b1);
        push_event(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
        // A frame that starts just short of the timestamp wrap.
        line_time = 32'hFFFF_FFF0;
        push_event(efr_pkg::OP_START, line_time, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b1, 0);
        push_edge_after(seg_delta(1), 1'b0);
        // The longest possible gap saturates to a run of all-zero bits.
        push_edge_after(32'hFFFF_FFFF, 1'b1);
        push_edge_after(seg_delta(2), 1'b1);
        add_byte(8'hA5, 1'b0, 1'b1, 3);
        push_edge_after(seg_delta(1), 1'b0);
        push_event(efr_pkg::OP_END, line_time, 1'b0);
        // An empty frame, then an edge with no time gone by.
        push_event(efr_pkg::OP_START, line_time, 1'b1);
        push_event(efr_pkg::OP_END, line_time, 1'b1);
        push_edge_after(32'd0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0, 0);
        push_edge_after(seg_delta(3), 1'b1);
        push_event(efr_pkg::OP_END, line_time, 1'b0);

        // Random part: mostly well-formed frames, the rest noise.
        while (pending_events.size() < EVENT_TARGET) begin
            if ($urandom_range(0, 99) < 85) begin
                add_frame();
            end else begin
                add_noise();
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_events.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        // Allow for the two-stage pipeline to show any stray result.
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
